### rtl/lfu_pkg.sv
// Shared constants and controller command type for the LFU page-frame table.
package lfu_pkg;

    localparam int FRAMES      = 8;
    localparam int PAGE_BITS   = 16;
    localparam int PAGE_IN_W   = 16;
    localparam int CFG_W       = 4;
    localparam int FIDX_OUT_W  = 3;
    localparam int COUNT_W     = 16;
    localparam int STAMP_W     = 32;
    localparam int FAULT_W     = 32;
    localparam int FIDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LEAVES      = 1 << FIDX_W;
    localparam int KEY_W       = 1 + COUNT_W + STAMP_W;
    localparam int M_TDATA_W   = 56;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

    typedef struct packed {
        logic load_in;
        logic eval;
        logic commit;
    } lfu_cmd_t;

endpackage

### rtl/lfu_ctrl.sv
// Controller: sequences accept, search and table update, owns the result valid flag.
module lfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lfu_pkg::lfu_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                // hold until the result register can take the item
                if (out_free) begin
                    cmd.commit = 1'b1;
                    s_tready   = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = S_EVAL;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_then_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_EVAL))
        else $error("accepted item not followed by search");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && out_valid_reg && !m_tready))
        else $error("result overwritten before it was taken");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

### rtl/lfu_dp.sv
// Datapath: frame table, tag compare, LFU victim tree, counters and result register.
module lfu_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lfu_pkg::lfu_cmd_t                    cmd,
    input  logic [lfu_pkg::PAGE_IN_W-1:0]        in_page,
    input  logic                                 in_new_run,
    input  logic                                 cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]            cfg_wdata,
    output logic [lfu_pkg::M_TDATA_W-1:0]        out_data
);

    typedef struct packed {
        logic                           active;
        logic [lfu_pkg::KEY_W-1:0]      key;
        logic [lfu_pkg::FIDX_W-1:0]     idx;
    } node_t;

    logic [lfu_pkg::PAGE_BITS-1:0]  page_reg [lfu_pkg::FRAMES];
    logic [lfu_pkg::FRAMES-1:0]     valid_reg, valid_next;
    logic [lfu_pkg::COUNT_W-1:0]    count_reg [lfu_pkg::FRAMES];
    logic [lfu_pkg::COUNT_W-1:0]    count_next [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_W-1:0]    stamp_reg [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_W-1:0]    stamp_next [lfu_pkg::FRAMES];
    logic [lfu_pkg::STAMP_W-1:0]    access_reg, access_next;
    logic [lfu_pkg::FAULT_W-1:0]    fault_reg, fault_next;
    logic [lfu_pkg::CFG_W-1:0]      frames_reg;

    logic [lfu_pkg::PAGE_BITS-1:0]  in_page_reg;
    logic                           in_new_run_reg;
    logic                           sel_hit_reg, sel_hit_next;
    logic [lfu_pkg::FIDX_W-1:0]     sel_slot_reg, sel_slot_next;
    logic [lfu_pkg::M_TDATA_W-1:0]  out_reg, out_next;

    logic [lfu_pkg::FRAMES-1:0]     act;
    logic [lfu_pkg::FRAMES-1:0]     eff_valid;
    logic [lfu_pkg::STAMP_W-1:0]    access_eff;
    logic [lfu_pkg::FAULT_W-1:0]    fault_eff;
    node_t                          tree [1:2*lfu_pkg::LEAVES-1];
    logic                           ev_valid;
    logic [lfu_pkg::PAGE_BITS-1:0]  ev_page;

    // a new run sees an empty table and zeroed counters
    always_comb begin
        for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
            act[i]       = (i == 0) || (i < int'(frames_reg));
            eff_valid[i] = valid_reg[i] && !in_new_run_reg;
        end
        access_eff = in_new_run_reg ? '0 : access_reg;
        fault_eff  = in_new_run_reg ? '0 : fault_reg;
    end

    // tag compare: lowest matching active frame
    always_comb begin
        sel_hit_next = 1'b0;
        for (int i = lfu_pkg::FRAMES - 1; i >= 0; i--) begin
            if (act[i] && eff_valid[i] && (page_reg[i] == in_page_reg)) begin
                sel_hit_next = 1'b1;
            end
        end
    end

    // victim tree: empty frames carry key zero, ties go to the left (lower index)
    always_comb begin
        for (int j = 0; j < lfu_pkg::LEAVES; j++) begin
            if (j < lfu_pkg::FRAMES) begin
                tree[lfu_pkg::LEAVES + j].active = act[j];
                tree[lfu_pkg::LEAVES + j].key    = eff_valid[j] ?
                    {1'b1, count_reg[j], stamp_reg[j]} : '0;
            end else begin
                tree[lfu_pkg::LEAVES + j].active = 1'b0;
                tree[lfu_pkg::LEAVES + j].key    = '0;
            end
            tree[lfu_pkg::LEAVES + j].idx = lfu_pkg::FIDX_W'(j);
        end
        for (int n = lfu_pkg::LEAVES - 1; n >= 1; n--) begin
            if (tree[2*n].active &&
                (!tree[2*n+1].active || (tree[2*n].key <= tree[2*n+1].key))) begin
                tree[n] = tree[2*n];
            end else begin
                tree[n] = tree[2*n+1];
            end
        end
    end

    always_comb begin
        sel_slot_next = tree[1].idx;
        for (int i = lfu_pkg::FRAMES - 1; i >= 0; i--) begin
            if (act[i] && eff_valid[i] && (page_reg[i] == in_page_reg)) begin
                sel_slot_next = lfu_pkg::FIDX_W'(i);
            end
        end
    end

    // table and counter update on commit
    always_comb begin
        for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
            valid_next[i] = eff_valid[i];
            count_next[i] = in_new_run_reg ? '0 : count_reg[i];
            stamp_next[i] = in_new_run_reg ? '0 : stamp_reg[i];
            if (sel_slot_reg == lfu_pkg::FIDX_W'(i)) begin
                if (sel_hit_reg) begin
                    if (count_reg[i] != '1) begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                end else begin
                    valid_next[i] = 1'b1;
                    count_next[i] = lfu_pkg::COUNT_W'(1);
                    stamp_next[i] = access_eff;
                end
            end
        end
        access_next = (access_eff == '1) ? access_eff : access_eff + 1'b1;
        if (!sel_hit_reg && (fault_eff != '1)) begin
            fault_next = fault_eff + 1'b1;
        end else begin
            fault_next = fault_eff;
        end
        ev_valid = !sel_hit_reg && eff_valid[sel_slot_reg];
        ev_page  = ev_valid ? page_reg[sel_slot_reg] : '0;
        out_next = {3'b000,
                    fault_next,
                    lfu_pkg::PAGE_IN_W'(ev_page),
                    ev_valid,
                    lfu_pkg::FIDX_OUT_W'(sel_slot_reg),
                    sel_hit_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            access_reg <= '0;
            fault_reg  <= '0;
            frames_reg <= lfu_pkg::FRAMES_RESET;
            for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
                count_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                frames_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                valid_reg  <= valid_next;
                access_reg <= access_next;
                fault_reg  <= fault_next;
                for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
                    count_reg[i] <= count_next[i];
                    stamp_reg[i] <= stamp_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && !sel_hit_reg) begin
            page_reg[sel_slot_reg] <= in_page_reg;
        end
        if (cmd.load_in) begin
            in_page_reg    <= lfu_pkg::PAGE_BITS'(in_page);
            in_new_run_reg <= in_new_run;
        end
        if (cmd.eval) begin
            sel_hit_reg  <= sel_hit_next;
            sel_slot_reg <= sel_slot_next;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> !(out_reg[0] && out_reg[4]))
        else $error("hit reported together with an eviction");

    a_fault_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !in_new_run_reg) |=> (fault_reg >= $past(fault_reg)))
        else $error("fault total fell within a run");

endmodule

### rtl/lfu_page_replacement.sv
// Top level of the LFU page-frame table: controller and datapath.
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_tvalid/s_tready  | tdata: page_number; tuser: new_run
//  m_       | out       | m_tvalid/m_tready  | tdata: hit, slot, evicted_valid,
//           |           |                    |        evicted_page, fault_total
//  cfg_     | in        | cfg_we             | cfg_wdata: frames_in_use
//
// Each item has a search cycle, for tag compare and the LFU victim tree over all
// frames, and an update cycle for the table and counter update, which lands in
// the result register. A new item is taken in the update cycle of the last one.
// Reset is synchronous; it empties the table and sets frames_in_use to 8.
// A result not taken holds the update cycle, and with it the input side.
module lfu_page_replacement (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfu_pkg::PAGE_IN_W-1:0]     s_tdata,  // [15:0] page_number
    input  logic                              s_tuser,  // [0] new_run
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] hit, [3:1] slot, [4] evicted_valid, [20:5] evicted_page,
    // [52:21] fault_total, [55:53] zero
    output logic [lfu_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]         cfg_wdata
);

    lfu_pkg::lfu_cmd_t cmd;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lfu_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_page    (s_tdata),
        .in_new_run (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_data   (m_tdata)
    );

endmodule
